@@ rtl/core/otc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otc_pkg
// Shared types and constants of the oversampled triggered capture unit.
// ----------------------------------------------------------------------------
package otc_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int COUNT_W    = 10;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 12;

   // raw samples per averaged point, and how many are held per dma group
   localparam int GROUP      = 4;
   localparam int OVERSAMPLE = 4;
   localparam int OS_SHIFT   = $clog2(OVERSAMPLE);
   localparam int SUM_W      = SAMPLE_W + OS_SHIFT;
   localparam int ROUND      = OVERSAMPLE / 2 + 1;

   // previous average carries one extra bit so it can sit above full scale
   localparam int PREV_W     = SAMPLE_W + 1;
   localparam logic [PREV_W-1:0]     PREV_RESET          = PREV_W'(4096);
   localparam logic [SAMPLE_W-1:0]   TRIGGER_LEVEL_RESET = SAMPLE_W'(2048);
   localparam logic [COUNT_W-1:0]    SAMPLE_COUNT_RESET  = COUNT_W'(256);

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_DMA   = 2'd1,
      OP_TICK  = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SKIPPED  = 2'd1,
      STATUS_ORDER    = 2'd2,
      STATUS_COMPLETE = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRIGGER_LEVEL = 1'b0,
      CSR_SAMPLE_COUNT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      status_type status;
      logic       triggered;
      logic       done;
      logic       read_hit;
   } result_type;

endpackage
`default_nettype wire

@@ rtl/core/otc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module otc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic                     read_enable,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/otc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otc_core
// Capture state, settings registers and per-item update logic: averaging,
// falling-edge trigger, ring drop and completion, plus store addressing.
// ----------------------------------------------------------------------------
module otc_core #(
   parameter int BUFFER_DEPTH = 512
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_write_enable,
   input  wire logic [otc_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire logic [otc_pkg::CSR_DATA_W-1:0]          csr_write_data,
   input  wire logic                                    item_fire,
   input  wire otc_pkg::opcode_type                     item_opcode,
   input  wire logic [otc_pkg::SAMPLE_W-1:0]            item_sample_a,
   input  wire logic [otc_pkg::SAMPLE_W-1:0]            item_sample_b,
   input  wire logic [otc_pkg::SAMPLE_W-1:0]            item_sample_c,
   input  wire logic [otc_pkg::SAMPLE_W-1:0]            item_sample_d,
   input  wire logic [$clog2(BUFFER_DEPTH)-1:0]         item_read_index,
   output otc_pkg::result_type                          result,
   output logic      [$clog2(BUFFER_DEPTH+1)-1:0]       fill_level,
   output logic                                         ram_write_enable,
   output logic      [$clog2(BUFFER_DEPTH)-1:0]         ram_write_addr,
   output logic      [otc_pkg::SAMPLE_W-1:0]            ram_write_data,
   output logic                                         ram_read_enable,
   output logic      [$clog2(BUFFER_DEPTH)-1:0]         ram_read_addr
);

   import otc_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int FW = $clog2(BUFFER_DEPTH + 1);
   localparam int QUARTER   = BUFFER_DEPTH / 4;
   localparam int DROP_MARK = (BUFFER_DEPTH * 3) / 4;
   localparam int LATCH_RESET = (256 > BUFFER_DEPTH) ? BUFFER_DEPTH : 256;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_ARMED,
      PHASE_READY,
      PHASE_DONE
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [SAMPLE_W-1:0]    held_ff [GROUP];
   logic [SAMPLE_W-1:0]    held_in [GROUP];
   logic [FW-1:0]          count_ff, count_in;
   logic [AW-1:0]          base_ff, base_in;
   logic                   trig_ff, trig_in;
   logic [PREV_W-1:0]      prev_ff, prev_in;
   logic [FW-1:0]          latched_ff, latched_in;
   logic [SAMPLE_W-1:0]    level_ff;
   logic [COUNT_W-1:0]     sample_count_ff;

   logic [SUM_W-1:0]       sum;
   logic [SAMPLE_W-1:0]    avg;
   logic [FW-1:0]          count_inc;
   logic                   trig_window;
   logic                   write_req;
   logic                   read_req;
   logic [AW-1:0]          write_pos;
   logic [AW-1:0]          read_pos;
   logic [AW-1:0]          base_adv;

   // operands stay below twice the depth, so one conditional subtract wraps
   function automatic logic [AW-1:0] wrap_addr(input logic [AW:0] value);
      logic [AW:0] trimmed;
      trimmed = (value >= (AW+1)'(BUFFER_DEPTH)) ? value - (AW+1)'(BUFFER_DEPTH) : value;
      return trimmed[AW-1:0];
   endfunction

   // rounded mean; four 12-bit samples plus rounding never exceed full scale
   always_comb begin
      sum = SUM_W'(ROUND);
      for (int i = 0; i < OVERSAMPLE; i++) begin
         sum = sum + SUM_W'(held_ff[i % GROUP]);
      end
   end
   assign avg = sum[SUM_W-1:OS_SHIFT];

   assign count_inc   = count_ff + FW'(1);
   assign trig_window = !trig_ff && (count_inc >= (latched_ff >> 1));
   assign write_pos   = wrap_addr({1'b0, base_ff} + (AW+1)'(count_ff));
   assign read_pos    = wrap_addr({1'b0, base_ff} + {1'b0, item_read_index});
   assign base_adv    = wrap_addr({1'b0, base_ff} + (AW+1)'(QUARTER));

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      count_in   = count_ff;
      base_in    = base_ff;
      trig_in    = trig_ff;
      prev_in    = prev_ff;
      latched_in = latched_ff;
      write_req  = 1'b0;
      read_req   = 1'b0;
      result.status   = STATUS_OK;
      result.read_hit = 1'b0;

      unique case (item_opcode)
         OP_START: begin
            if (32'(sample_count_ff) > 32'(BUFFER_DEPTH)) begin
               latched_in = FW'(BUFFER_DEPTH);
            end else begin
               latched_in = FW'(sample_count_ff);
            end
            count_in = '0;
            base_in  = '0;
            trig_in  = 1'b0;
            prev_in  = PREV_RESET;
            phase_in = PHASE_ARMED;
         end
         OP_DMA: begin
            if (phase_ff == PHASE_ARMED) begin
               held_in[0] = item_sample_a;
               held_in[1] = item_sample_b;
               held_in[2] = item_sample_c;
               held_in[3] = item_sample_d;
               phase_in   = PHASE_READY;
            end else begin
               result.status = STATUS_ORDER;
            end
         end
         OP_TICK: begin
            if (phase_ff == PHASE_READY) begin
               write_req = 1'b1;
               count_in  = count_inc;
               phase_in  = PHASE_ARMED;
               if (trig_window) begin
                  prev_in = {1'b0, avg};
               end
               priority if (trig_window && (prev_ff > {1'b0, level_ff}) && (avg < level_ff)) begin
                  trig_in = 1'b1;
               end else if (!trig_ff && (32'(count_inc) > 32'(DROP_MARK))) begin
                  // untriggered and nearly full: forget the oldest quarter
                  base_in  = base_adv;
                  count_in = count_inc - FW'(QUARTER);
               end else if (count_inc >= latched_ff) begin
                  phase_in      = PHASE_DONE;
                  result.status = STATUS_COMPLETE;
               end else begin
                  phase_in = PHASE_ARMED;
               end
            end else if (phase_ff == PHASE_ARMED) begin
               result.status = STATUS_SKIPPED;
            end else begin
               result.status = STATUS_ORDER;
            end
         end
         OP_READ: begin
            if (FW'(item_read_index) < count_ff) begin
               read_req        = 1'b1;
               result.read_hit = 1'b1;
            end else begin
               result.status = STATUS_ORDER;
            end
         end
         default: begin
            result.status = STATUS_ORDER;
         end
      endcase

      result.triggered = trig_in;
      result.done      = (phase_in == PHASE_DONE);
   end

   assign fill_level       = count_in;
   assign ram_write_enable = item_fire && write_req;
   assign ram_write_addr   = write_pos;
   assign ram_write_data   = avg;
   assign ram_read_enable  = item_fire && read_req;
   assign ram_read_addr    = read_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_IDLE;
         for (int i = 0; i < GROUP; i++) begin
            held_ff[i] <= '0;
         end
         count_ff        <= '0;
         base_ff         <= '0;
         trig_ff         <= 1'b0;
         prev_ff         <= PREV_RESET;
         latched_ff      <= FW'(LATCH_RESET);
         level_ff        <= TRIGGER_LEVEL_RESET;
         sample_count_ff <= SAMPLE_COUNT_RESET;
      end else begin
         if (item_fire) begin
            phase_ff   <= phase_in;
            held_ff    <= held_in;
            count_ff   <= count_in;
            base_ff    <= base_in;
            trig_ff    <= trig_in;
            prev_ff    <= prev_in;
            latched_ff <= latched_in;
         end
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_TRIGGER_LEVEL: level_ff        <= csr_write_data[SAMPLE_W-1:0];
               CSR_SAMPLE_COUNT:  sample_count_ff <= csr_write_data[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/oversampled_triggered_capture_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oversampled_triggered_capture_unit
// Oversampled, falling-edge triggered capture into a circular sample store.
// ----------------------------------------------------------------------------
// Every request gives exactly one response. One request is taken per clock
// cycle when the response side keeps up; a request's response passes through
// the input register first, then the state update, the averaging and the
// sample store access land in the response register together. The sample
// store is a BUFFER_DEPTH x 12 RAM with one write and one registered read
// port; each request uses at most one of them. Stored entries are only read
// below the fill level, so the store needs no clearing after reset. Settings
// writes must be made only while no request is in flight; the block itself
// does not enforce this. sample_count is latched by the start opcode.
module oversampled_triggered_capture_unit #(
   parameter int BUFFER_DEPTH = 512
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_opcode,
   input  wire logic [otc_pkg::SAMPLE_W-1:0]         req_sample_a,
   input  wire logic [otc_pkg::SAMPLE_W-1:0]         req_sample_b,
   input  wire logic [otc_pkg::SAMPLE_W-1:0]         req_sample_c,
   input  wire logic [otc_pkg::SAMPLE_W-1:0]         req_sample_d,
   input  wire logic [$clog2(BUFFER_DEPTH)-1:0]      req_read_index,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [1:0]                           rsp_status,
   output logic      [otc_pkg::SAMPLE_W-1:0]         rsp_sample_value,
   output logic                                      rsp_is_triggered,
   output logic                                      rsp_is_done,
   output logic      [$clog2(BUFFER_DEPTH+1)-1:0]    rsp_fill_level,
   input  wire logic                                 csr_write_enable,
   input  wire logic [otc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [otc_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   import otc_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int FW = $clog2(BUFFER_DEPTH + 1);

   logic                s1_valid_ff;
   opcode_type          s1_opcode_ff;
   logic [SAMPLE_W-1:0] s1_sample_a_ff;
   logic [SAMPLE_W-1:0] s1_sample_b_ff;
   logic [SAMPLE_W-1:0] s1_sample_c_ff;
   logic [SAMPLE_W-1:0] s1_sample_d_ff;
   logic [AW-1:0]       s1_read_index_ff;

   logic                rsp_valid_ff;
   result_type          rsp_result_ff;
   logic [FW-1:0]       rsp_fill_ff;

   logic                rsp_load;
   logic                s1_load;
   logic                s1_fire;
   logic                req_accept;

   result_type          core_result;
   logic [FW-1:0]       core_fill;
   logic                ram_write_enable;
   logic [AW-1:0]       ram_write_addr;
   logic [SAMPLE_W-1:0] ram_write_data;
   logic                ram_read_enable;
   logic [AW-1:0]       ram_read_addr;
   logic [SAMPLE_W-1:0] ram_read_data;

   // response register frees up when empty or when its transfer completes
   assign rsp_load   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && rsp_load;
   assign s1_load    = !s1_valid_ff || rsp_load;
   assign req_stall  = !s1_load;
   assign req_accept = req_valid && s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_valid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_opcode_ff     <= opcode_type'(req_opcode);
         s1_sample_a_ff   <= req_sample_a;
         s1_sample_b_ff   <= req_sample_b;
         s1_sample_c_ff   <= req_sample_c;
         s1_sample_d_ff   <= req_sample_d;
         s1_read_index_ff <= req_read_index;
      end
      if (s1_fire) begin
         rsp_result_ff <= core_result;
         rsp_fill_ff   <= core_fill;
      end
   end

   otc_core #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .item_fire        (s1_fire),
      .item_opcode      (s1_opcode_ff),
      .item_sample_a    (s1_sample_a_ff),
      .item_sample_b    (s1_sample_b_ff),
      .item_sample_c    (s1_sample_c_ff),
      .item_sample_d    (s1_sample_d_ff),
      .item_read_index  (s1_read_index_ff),
      .result           (core_result),
      .fill_level       (core_fill),
      .ram_write_enable (ram_write_enable),
      .ram_write_addr   (ram_write_addr),
      .ram_write_data   (ram_write_data),
      .ram_read_enable  (ram_read_enable),
      .ram_read_addr    (ram_read_addr)
   );

   // read data register only moves on a read transfer, so it holds under stall
   otc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock        (clock),
      .write_enable (ram_write_enable),
      .write_addr   (ram_write_addr),
      .write_data   (ram_write_data),
      .read_enable  (ram_read_enable),
      .read_addr    (ram_read_addr),
      .read_data    (ram_read_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_result_ff.status;
   assign rsp_sample_value = rsp_result_ff.read_hit ? ram_read_data : '0;
   assign rsp_is_triggered = rsp_result_ff.triggered;
   assign rsp_is_done      = rsp_result_ff.done;
   assign rsp_fill_level   = rsp_fill_ff;

endmodule
`default_nettype wire

@@ rtl/core/otc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otc_checker
// Port-level checks of the capture unit's responses, bound to the top level.
// ----------------------------------------------------------------------------
module otc_checker #(
   parameter int BUFFER_DEPTH = 512
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   input  wire logic [1:0]                           rsp_status,
   input  wire logic [otc_pkg::SAMPLE_W-1:0]         rsp_sample_value,
   input  wire logic                                 rsp_is_triggered,
   input  wire logic                                 rsp_is_done,
   input  wire logic [$clog2(BUFFER_DEPTH+1)-1:0]    rsp_fill_level
);

   import otc_pkg::*;

   localparam int FW = $clog2(BUFFER_DEPTH + 1);

   // a stalled response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_sample_value) && $stable(rsp_fill_level)
         && $stable(rsp_is_triggered) && $stable(rsp_is_done))
      else $error("stalled response changed");

   // completion status only comes with the done flag
   a_complete_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_COMPLETE) |-> rsp_is_done)
      else $error("completion without done flag");

   // a skipped tick happens only while armed, never after completion
   a_skip_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_SKIPPED) |-> !rsp_is_done)
      else $error("skipped tick reported on a completed capture");

   // a nonzero sample only comes from an in-range read
   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sample_value != '0) |-> (rsp_status == STATUS_OK)
         && (rsp_fill_level != '0))
      else $error("sample value on a failed read");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fill_level <= FW'(BUFFER_DEPTH))
      else $error("fill level beyond store depth");

endmodule

bind oversampled_triggered_capture_unit otc_checker #(
   .BUFFER_DEPTH (BUFFER_DEPTH)
) u_otc_checker (.*);
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the oversampled triggered capture unit.
// ----------------------------------------------------------------------------
// Requests go in through the req_ channel. A behavioral copy of the capture
// logic predicts the single response of each accepted request, and every
// response transfer is checked field by field against the oldest prediction.
// Directed cases cover idle-state requests, averaging extremes, trigger,
// completion and very short counts. A long untriggered capture exercises the
// ring drop under each flow pattern. Randomized captures then run under
// changing flow control.
// ----------------------------------------------------------------------------
module tb;
   import otc_pkg::*;

   localparam int DEPTH        = 512;
   localparam int LIMIT_CYCLES = 200000;
   localparam int DROP_PAIRS   = 388;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_ARMED = 2'd1,
      PHASE_READY = 2'd2,
      PHASE_DONE  = 2'd3
   } capture_phase_type;

   typedef struct packed {
      opcode_type                      opcode;
      logic [GROUP-1:0][SAMPLE_W-1:0]  samples;
      logic [8:0]                      read_index;
   } capture_req_type;

   typedef struct packed {
      status_type          status;
      logic [SAMPLE_W-1:0] sample_value;
      logic                is_triggered;
      logic                is_done;
      logic [9:0]          fill_level;
   } capture_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_opcode = OP_READ;
   logic [SAMPLE_W-1:0]    req_sample_a = '0;
   logic [SAMPLE_W-1:0]    req_sample_b = '0;
   logic [SAMPLE_W-1:0]    req_sample_c = '0;
   logic [SAMPLE_W-1:0]    req_sample_d = '0;
   logic [8:0]             req_read_index = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_status;
   logic [SAMPLE_W-1:0]    rsp_sample_value;
   logic                   rsp_is_triggered;
   logic                   rsp_is_done;
   logic [9:0]             rsp_fill_level;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_TRIGGER_LEVEL;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   oversampled_triggered_capture_unit #(
      .BUFFER_DEPTH(DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_sample_a     (req_sample_a),
      .req_sample_b     (req_sample_b),
      .req_sample_c     (req_sample_c),
      .req_sample_d     (req_sample_d),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_sample_value (rsp_sample_value),
      .rsp_is_triggered (rsp_is_triggered),
      .rsp_is_done      (rsp_is_done),
      .rsp_fill_level   (rsp_fill_level),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // capture model state
   capture_phase_type               phase_model = PHASE_IDLE;
   logic [GROUP-1:0][SAMPLE_W-1:0]  group_model = '0;
   logic [9:0]                      write_count_model = '0;
   logic [8:0]                      ring_base_model = '0;
   logic                            trigger_model = 1'b0;
   logic [PREV_W-1:0]               last_average_model = PREV_RESET;
   int unsigned                     latched_count_model = 256;
   logic [SAMPLE_W-1:0]             store_model [DEPTH];
   logic [SAMPLE_W-1:0]             level_setting = TRIGGER_LEVEL_RESET;
   logic [COUNT_W-1:0]              count_setting = SAMPLE_COUNT_RESET;

   capture_result_type expected_responses [$];
   int unsigned     sender_idle_pct = 0;
   int unsigned     stall_pct = 0;
   int unsigned     requests_sent = 0;
   int unsigned     responses_checked = 0;
   int unsigned     random_captures = 0;
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count = 0;

   function automatic capture_result_type predict_capture(input capture_req_type r);
      capture_result_type res;
      int unsigned     sum;
      int unsigned     avg;
      int unsigned     prior_avg;
      bit              settled;
      res = '0;
      res.status = STATUS_OK;
      case (r.opcode)
         OP_START: begin
            latched_count_model = (count_setting > DEPTH) ? DEPTH : count_setting;
            write_count_model = '0;
            ring_base_model = '0;
            trigger_model = 1'b0;
            last_average_model = PREV_RESET;
            phase_model = PHASE_ARMED;
         end
         OP_DMA: begin
            if (phase_model == PHASE_ARMED) begin
               group_model = r.samples;
               phase_model = PHASE_READY;
            end else begin
               res.status = STATUS_ORDER;
            end
         end
         OP_TICK: begin
            if (phase_model == PHASE_READY) begin
               sum = 0;
               for (int i = 0; i < OVERSAMPLE; i++) sum += group_model[i % GROUP];
               avg = (sum + OVERSAMPLE / 2 + 1) / OVERSAMPLE;
               if (avg > 4095) avg = 4095;
               store_model[(ring_base_model + write_count_model) % DEPTH] = avg[11:0];
               write_count_model++;
               settled = 1'b0;
               // trigger is only looked for from half the count on
               if (!trigger_model && write_count_model >= latched_count_model / 2) begin
                  prior_avg = last_average_model;
                  last_average_model = avg[12:0];
                  if (prior_avg > level_setting && avg < level_setting) begin
                     trigger_model = 1'b1;
                     phase_model = PHASE_ARMED;
                     settled = 1'b1;
                  end
               end
               // untriggered and past 3/4 full: drop the oldest quarter
               if (!settled && !trigger_model && write_count_model > DEPTH * 3 / 4) begin
                  ring_base_model = ring_base_model + 9'(DEPTH / 4);
                  write_count_model = write_count_model - 10'(DEPTH / 4);
                  phase_model = PHASE_ARMED;
                  settled = 1'b1;
               end
               if (!settled) begin
                  if (write_count_model >= latched_count_model) begin
                     phase_model = PHASE_DONE;
                     res.status = STATUS_COMPLETE;
                  end else begin
                     phase_model = PHASE_ARMED;
                  end
               end
            end else if (phase_model == PHASE_ARMED) begin
               res.status = STATUS_SKIPPED;
            end else begin
               res.status = STATUS_ORDER;
            end
         end
         default: begin
            if (r.read_index < write_count_model)
               res.sample_value = store_model[(ring_base_model + r.read_index) % DEPTH];
            else
               res.status = STATUS_ORDER;
         end
      endcase
      res.is_triggered = trigger_model;
      res.is_done = (phase_model == PHASE_DONE);
      res.fill_level = write_count_model;
      return res;
   endfunction

   function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
      if (v < 0) return '0;
      if (v > 4095) return 12'hfff;
      return 12'(v);
   endfunction

   function automatic logic [8:0] pick_read_index();
      if (write_count_model != 0 && $urandom_range(3) != 0)
         return 9'($urandom_range(write_count_model - 1));
      return 9'($urandom_range(DEPTH - 1));
   endfunction

   task automatic set_flow(input int unsigned sender_pct, input int unsigned receiver_pct);
      sender_idle_pct = sender_pct;
      stall_pct = receiver_pct;
   endtask

   task automatic issue_request(input capture_req_type r);
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_sample_a <= r.samples[0];
      req_sample_b <= r.samples[1];
      req_sample_c <= r.samples[2];
      req_sample_d <= r.samples[3];
      req_read_index <= r.read_index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_responses.push_back(predict_capture(r));
      requests_sent++;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
   endtask

   // unused fields carry random bits
   task automatic send_op(input opcode_type op);
      capture_req_type r;
      r.opcode = op;
      for (int i = 0; i < GROUP; i++) r.samples[i] = 12'($urandom);
      r.read_index = 9'($urandom);
      issue_request(r);
   endtask

   task automatic send_group(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                             input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] d);
      capture_req_type r;
      r.opcode = OP_DMA;
      r.samples = {d, c, b, a};
      r.read_index = 9'($urandom);
      issue_request(r);
   endtask

   task automatic send_read(input logic [8:0] index);
      capture_req_type r;
      r.opcode = OP_READ;
      for (int i = 0; i < GROUP; i++) r.samples[i] = 12'($urandom);
      r.read_index = index;
      issue_request(r);
   endtask

   task automatic send_random_group();
      send_group(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
      // input and response registers only, so the wait below leaves both empty
      repeat (4) @(posedge clock);
   endtask

   // both registers every time, so the write enable is never toggled within a step
   task automatic write_settings(input logic [SAMPLE_W-1:0] level, input logic [COUNT_W-1:0] count);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_TRIGGER_LEVEL;
      csr_write_data <= level;
      @(posedge clock);
      level_setting = level;
      csr_index <= CSR_SAMPLE_COUNT;
      csr_write_data <= CSR_DATA_W'(count);
      @(posedge clock);
      count_setting = count;
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_idle_requests();
      set_flow(0, 0);
      send_op(OP_TICK);
      send_group(12'hfff, 12'hfff, 12'hfff, 12'hfff);
      send_read(9'(DEPTH - 1));
   endtask

   task automatic test_average_extremes();
      send_op(OP_START);
      send_op(OP_TICK);
      send_group(12'hfff, 12'hfff, 12'hfff, 12'hfff);
      send_group(12'h000, 12'h000, 12'h000, 12'h000);
      send_op(OP_TICK);
      send_read(9'd0);
      send_read(9'd1);
   endtask

   task automatic test_trigger_and_complete();
      drain_responses();
      write_settings(TRIGGER_LEVEL_RESET, 10'd2);
      send_op(OP_START);
      send_group(12'h000, 12'h000, 12'h000, 12'h000);
      send_op(OP_TICK);
      send_group(12'h000, 12'hfff, 12'h001, 12'h002);
      send_op(OP_TICK);
      send_op(OP_TICK);
      send_read(9'd1);
   endtask

   task automatic test_short_counts();
      drain_responses();
      write_settings(12'h000, 10'd0);
      send_op(OP_START);
      send_group(12'hfff, 12'hfff, 12'hfff, 12'hfff);
      send_op(OP_TICK);
      drain_responses();
      write_settings(12'hfff, 10'd1);
      send_op(OP_START);
      send_group(12'h000, 12'h000, 12'h000, 12'h000);
      send_op(OP_TICK);
      send_group(12'hfff, 12'hfff, 12'hfff, 12'hfff);
      send_op(OP_TICK);
   endtask

   // level zero never triggers, so past 3/4 full the base moves by a quarter
   task automatic test_ring_drop();
      int unsigned n;
      drain_responses();
      write_settings(12'h000, 10'(DEPTH));
      send_op(OP_START);
      for (n = 0; n < DROP_PAIRS; n++) begin
         case ((n * 4) / DROP_PAIRS)
            0: set_flow(0, 0);
            1: set_flow(51, 0);
            2: set_flow(0, 51);
            default: set_flow(9, 9);
         endcase
         send_random_group();
         send_op(OP_TICK);
      end
      repeat (8) send_read(pick_read_index());
   endtask

   task automatic test_random_captures(input int unsigned target);
      int unsigned first;
      int unsigned in_capture;
      int unsigned pick;
      int          wave;
      logic [SAMPLE_W-1:0] level;
      logic [COUNT_W-1:0]  count;
      first = requests_sent;
      while (requests_sent - first < target) begin
         case (((requests_sent - first) * 4) / target)
            0: set_flow(0, 0);
            1: set_flow(51, 0);
            2: set_flow(0, 51);
            default: set_flow(9, 9);
         endcase
         drain_responses();
         pick = $urandom_range(15);
         if (pick == 0) count = 10'($urandom_range(1023));
         else if (pick == 1) count = 10'($urandom_range(1));
         else count = 10'($urandom_range(40, 2));
         level = 12'($urandom);
         write_settings(level, count);
         send_op(OP_START);
         random_captures++;
         wave = int'($urandom_range(4095));
         in_capture = 0;
         while (phase_model != PHASE_DONE && in_capture < 80) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
               if ($urandom_range(9) == 0) begin
                  send_random_group();
               end else begin
                  // slow wandering signal so the level gets crossed both ways
                  wave = int'(clamp_sample(wave + int'($urandom_range(1200)) - 600));
                  send_group(clamp_sample(wave + int'($urandom_range(30)) - 15),
                             clamp_sample(wave + int'($urandom_range(30)) - 15),
                             clamp_sample(wave + int'($urandom_range(30)) - 15),
                             clamp_sample(wave + int'($urandom_range(30)) - 15));
               end
               send_op(OP_TICK);
               in_capture += 2;
            end else if (pick < 87) begin
               send_read(pick_read_index());
               in_capture++;
            end else if (pick < 92) begin
               send_op(OP_TICK);
               in_capture++;
            end else if (pick < 97) begin
               send_random_group();
               in_capture++;
            end else begin
               send_op(OP_START);
               in_capture++;
            end
         end
         send_read(pick_read_index());
         send_read(pick_read_index());
      end
   endtask

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      capture_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            $error("response transfer with nothing expected: status %0d, fill_level %0d",
                   rsp_status, rsp_fill_level);
            mismatch_count++;
         end else begin
            want = expected_responses.pop_front();
            responses_checked++;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_sample_value !== want.sample_value) begin
               $error("sample_value: expected %0d, got %0d", want.sample_value,
                      rsp_sample_value);
               mismatch_count++;
            end
            if (rsp_is_triggered !== want.is_triggered) begin
               $error("is_triggered: expected %0d, got %0d", want.is_triggered,
                      rsp_is_triggered);
               mismatch_count++;
            end
            if (rsp_is_done !== want.is_done) begin
               $error("is_done: expected %0d, got %0d", want.is_done, rsp_is_done);
               mismatch_count++;
            end
            if (rsp_fill_level !== want.fill_level) begin
               $error("fill_level: expected %0d, got %0d", want.fill_level, rsp_fill_level);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_requests();
      test_average_extremes();
      test_trigger_and_complete();
      test_short_counts();
      test_ring_drop();
      test_random_captures(80);
      drain_responses();
      $display("run covered %0d requests and %0d checked responses", requests_sent,
               responses_checked);
      $display("directed cases, one ring drop capture and %0d random captures",
               random_captures);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
